// ===== hdl/srf_pkg.sv =====
// Shared constants for the refraction and Fresnel pipeline.
`timescale 1ns / 1ps
package srf_pkg;
  localparam int VEC_W = 16;
  localparam int IDX_W = 14;
  localparam logic [IDX_W-1:0] IDX_ONE = 14'd4096;
  localparam logic [IDX_W-1:0] IDX_MIN = 14'd1;
  localparam logic [15:0] REFL_MAX = 16'hFFFF;
  localparam int TUSER_TIR = 0;
  localparam int TUSER_EXIT = 1;
  localparam int IN_TDATA_W = 112;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;
endpackage

// ===== hdl/snell_refraction_fresnel_top.sv =====
// Snell refraction with Fresnel reflectance: streaming top level.
//
//  channel | dir | tdata fields (low bit up)                              | tuser
//  in_     | in  | dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, medium_idx | -
//  out_    | out | out_x, out_y, out_z, reflectance                        | total_reflect, exiting
//
// One ray per cycle while the output is not stalled; the pipeline runs through bit-per-stage
// dividers and a bit-per-stage square-root pipeline.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stall holds every stage only when the last stage and the output register are both full.
`timescale 1ns / 1ps
module snell_refraction_fresnel_top #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [srf_pkg::IN_TDATA_W-1:0]     in_tdata,  // dir_x,dir_y,dir_z,norm_x,norm_y,norm_z,medium_index
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [srf_pkg::OUT_TDATA_W-1:0]    out_tdata, // out_x,out_y,out_z,reflectance
  output logic [srf_pkg::OUT_TUSER_W-1:0]    out_tuser  // total_reflect,exiting
);
  import srf_pkg::*;

  localparam int F     = VEC_FRAC_BITS;
  localparam int CI_W  = F + 1;
  localparam int DOT_W = 34;
  localparam int SM_W  = CI_W + IDX_W;
  localparam int NE_W  = SM_W + IDX_W;
  localparam int DE_W  = 2 * IDX_W;
  localparam int KA_W  = 2 * CI_W - 1;
  localparam int NC_W  = CI_W + IDX_W;
  localparam int RN_W  = NC_W + 16;
  localparam int RD_W  = NC_W + 1;
  localparam int ND_W  = VEC_W + IDX_W;
  localparam int EQ_W  = (F + 13 > 28) ? F + 13 : 28;
  localparam int CO_W  = EQ_W + 2;
  localparam int ED_W  = EQ_W + 1;
  localparam int NV_W  = VEC_W + 1;
  localparam int PR_W  = CO_W + NV_W;
  localparam int T_W   = PR_W + 1;
  localparam int NV_O  = 0;
  localparam int D_O   = 3 * NV_W;
  localparam int M_O   = D_O + 3 * VEC_W;
  localparam int CI_O  = M_O + IDX_W;
  localparam int EX_O  = CI_O + CI_W;
  localparam int SA_W  = EX_O + 1;
  localparam int MB_W  = 6 + CI_W + 3 * NV_W;

  localparam logic signed [DOT_W-1:0] ONE_D = DOT_W'(1) << F;
  localparam logic [CI_W-1:0]         ONE_C = CI_W'(1) << F;
  localparam logic signed [T_W-1:0]   SAT_HI = T_W'(32767);
  localparam logic signed [T_W-1:0]   SAT_LO = -T_W'(32768);

  logic adv;

  // ---- stage 1: products ----
  logic                    st1_v_r;
  logic signed [31:0]      st1_p_r [3];
  logic [3*VEC_W-1:0]      st1_d_r, st1_n_r;
  logic [IDX_W-1:0]        st1_m_r;
  logic signed [31:0]      st1_p_nxt [3];
  logic [IDX_W-1:0]        st1_m_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++)
      st1_p_nxt[i] = $signed(in_tdata[VEC_W*i +: VEC_W]) * $signed(in_tdata[VEC_W*(i+3) +: VEC_W]);
    st1_m_nxt = (in_tdata[96 +: IDX_W] == '0) ? IDX_MIN : in_tdata[96 +: IDX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st1_v_r <= 1'b0;
    else if (adv) st1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st1_p_r <= st1_p_nxt;
      st1_d_r <= in_tdata[0 +: 3*VEC_W];
      st1_n_r <= in_tdata[3*VEC_W +: 3*VEC_W];
      st1_m_r <= st1_m_nxt;
    end
  end

  // ---- stage 2: dot, clamp, side select ----
  logic signed [DOT_W-1:0] dot, cs_sh, cs, cs_neg;
  logic                    ex2;
  logic [CI_W-1:0]         ci2;
  logic [3*NV_W-1:0]       nv2;
  logic [SA_W-1:0]         st2_sa_nxt, st2_sa_r;
  logic                    st2_v_r;

  always_comb begin
    dot = DOT_W'(st1_p_r[0]) + DOT_W'(st1_p_r[1]) + DOT_W'(st1_p_r[2]);
    cs_sh = dot >>> F;
    priority if (cs_sh > ONE_D) cs = ONE_D;
    else if (cs_sh < -ONE_D) cs = -ONE_D;
    else cs = cs_sh;
    cs_neg = -cs;
    ex2 = ~cs[DOT_W-1];
    ci2 = ex2 ? cs[CI_W-1:0] : cs_neg[CI_W-1:0];
    for (int i = 0; i < 3; i++)
      nv2[NV_W*i +: NV_W] = ex2 ? -NV_W'($signed(st1_n_r[VEC_W*i +: VEC_W]))
                                : NV_W'($signed(st1_n_r[VEC_W*i +: VEC_W]));
    st2_sa_nxt = {ex2, ci2, st1_m_r, st1_d_r, nv2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st2_v_r <= 1'b0;
    else if (adv) st2_v_r <= st1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) st2_sa_r <= st2_sa_nxt;
  end

  // ---- stage 3: s2 = 1 - ci^2 ----
  logic [2*CI_W-1:0] cc_full;
  logic [CI_W-1:0]   s2_nxt, st3_s2_r;
  logic [SA_W-1:0]   st3_sa_r;
  logic              st3_v_r;

  always_comb begin
    cc_full = st2_sa_r[CI_O +: CI_W] * st2_sa_r[CI_O +: CI_W];
    s2_nxt  = ONE_C - CI_W'(cc_full >> F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st3_v_r <= 1'b0;
    else if (adv) st3_v_r <= st2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st3_s2_r <= s2_nxt;
      st3_sa_r <= st2_sa_r;
    end
  end

  // ---- stages 4/5: eta^2 sin^2 numerator and denominator ----
  logic [IDX_W-1:0] mul4, mul5, m3;
  logic [SM_W-1:0]  sm_nxt, st4_sm_r;
  logic [DE_W-1:0]  den4_nxt, st4_den_r, st5_den_r;
  logic [NE_W-1:0]  num5_nxt, st5_num_r;
  logic [SA_W-1:0]  st4_sa_r, st5_sa_r;
  logic             st4_v_r, st5_v_r;

  always_comb begin
    m3       = st3_sa_r[M_O +: IDX_W];
    mul4     = st3_sa_r[EX_O] ? m3 : IDX_ONE;
    sm_nxt   = SM_W'(st3_s2_r) * SM_W'(mul4);
    den4_nxt = st3_sa_r[EX_O] ? (DE_W'(1) << 24) : DE_W'(m3) * DE_W'(m3);
    mul5     = st4_sa_r[EX_O] ? st4_sa_r[M_O +: IDX_W] : IDX_ONE;
    num5_nxt = NE_W'(st4_sm_r) * NE_W'(mul5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
      st5_v_r <= 1'b0;
    end else if (adv) begin
      st4_v_r <= st3_v_r;
      st5_v_r <= st4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st4_sm_r  <= sm_nxt;
      st4_den_r <= den4_nxt;
      st4_sa_r  <= st3_sa_r;
      st5_num_r <= num5_nxt;
      st5_den_r <= st4_den_r;
      st5_sa_r  <= st4_sa_r;
    end
  end

  // ---- es2 division ----
  logic [CI_W-1:0] es2;
  logic            es2_ovf;
  logic            de_v;
  logic [SA_W-1:0] de_sa;

  srf_div #(.NUM_W(NE_W), .DEN_W(DE_W), .Q_W(CI_W)) u_div_es2 (
    .clk(clk), .en(adv), .num(st5_num_r), .den(st5_den_r),
    .q(es2), .rem_nz(), .ovf(es2_ovf)
  );
  srf_delay #(.W(SA_W), .D(CI_W)) u_dly_es2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(st5_v_r), .din(st5_sa_r),
    .vld_out(de_v), .dout(de_sa)
  );

  // ---- stage K: k, flags, root argument ----
  logic            kpos_nxt, tir_nxt;
  logic [KA_W-1:0] karg_nxt, stk_arg_r;
  logic [SA_W-1:0] stk_sa_r;
  logic            stk_v_r, stk_tir_r, stk_kpos_r;

  always_comb begin
    kpos_nxt = !es2_ovf && (es2 < ONE_C);
    tir_nxt  = es2_ovf || (es2 > ONE_C);
    karg_nxt = kpos_nxt ? (KA_W'(ONE_C - es2) << F) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) stk_v_r <= 1'b0;
    else if (adv) stk_v_r <= de_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      stk_arg_r  <= karg_nxt;
      stk_sa_r   <= de_sa;
      stk_tir_r  <= tir_nxt;
      stk_kpos_r <= kpos_nxt;
    end
  end

  // ---- square root ----
  logic [CI_W-1:0]   sk;
  logic              ds_v;
  logic [SA_W+1:0]   ds_vec;

  srf_sqrt #(.RW(CI_W)) u_sqrt (
    .clk(clk), .en(adv), .arg(stk_arg_r), .root(sk)
  );
  srf_delay #(.W(SA_W + 2), .D(CI_W)) u_dly_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(stk_v_r),
    .din({stk_tir_r, stk_kpos_r, stk_sa_r}), .vld_out(ds_v), .dout(ds_vec)
  );

  // ---- stage M1: eta products and Fresnel terms ----
  logic             ex_m, tir_m, kpos_m;
  logic [IDX_W-1:0] m_m, mul_m, den_m;
  logic [CI_W-1:0]  ci_m;
  logic [NC_W-1:0]  nci_nxt, ps_nxt, qs_nxt, qp_nxt;
  logic [ND_W-1:0]  nd_nxt [3];
  logic [2:0]       dneg_nxt;
  logic [VEC_W:0]   dneg_val;
  logic [VEC_W-1:0] dmag;

  logic             m1_v_r, m1_ex_r, m1_tir_r, m1_kpos_r;
  logic [NC_W-1:0]  m1_nci_r, m1_ps_r, m1_qs_r, m1_qp_r;
  logic [IDX_W-1:0] m1_den_r;
  logic [ND_W-1:0]  m1_nd_r [3];
  logic [2:0]       m1_dneg_r;
  logic [CI_W-1:0]  m1_sk_r;
  logic [3*NV_W-1:0] m1_nv_r;

  always_comb begin
    tir_m  = ds_vec[SA_W+1];
    kpos_m = ds_vec[SA_W];
    ex_m   = ds_vec[EX_O];
    ci_m   = ds_vec[CI_O +: CI_W];
    m_m    = ds_vec[M_O +: IDX_W];
    mul_m  = ex_m ? m_m : IDX_ONE;
    den_m  = ex_m ? IDX_ONE : m_m;
    nci_nxt = NC_W'(ci_m) * NC_W'(mul_m);
    ps_nxt  = NC_W'(ci_m) * NC_W'(den_m);
    qs_nxt  = NC_W'(sk) * NC_W'(mul_m);
    qp_nxt  = NC_W'(sk) * NC_W'(den_m);
    for (int i = 0; i < 3; i++) begin
      dneg_nxt[i] = ds_vec[D_O + VEC_W*i + VEC_W - 1];
      dneg_val    = -(VEC_W+1)'($signed(ds_vec[D_O + VEC_W*i +: VEC_W]));
      dmag        = dneg_nxt[i] ? dneg_val[VEC_W-1:0] : ds_vec[D_O + VEC_W*i +: VEC_W];
      nd_nxt[i]   = ND_W'(dmag) * ND_W'(mul_m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (adv) m1_v_r <= ds_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_ex_r   <= ex_m;
      m1_tir_r  <= tir_m;
      m1_kpos_r <= kpos_m;
      m1_nci_r  <= nci_nxt;
      m1_ps_r   <= ps_nxt;
      m1_qs_r   <= qs_nxt;
      m1_qp_r   <= qp_nxt;
      m1_den_r  <= den_m;
      m1_nd_r   <= nd_nxt;
      m1_dneg_r <= dneg_nxt;
      m1_sk_r   <= sk;
      m1_nv_r   <= ds_vec[NV_O +: 3*NV_W];
    end
  end

  // ---- stage M2: Fresnel difference and sum ----
  logic [NC_W-1:0]  rs_diff, rp_diff;
  logic             m2_v_r;
  logic [NC_W-1:0]  m2_nci_r;
  logic [IDX_W-1:0] m2_den_r;
  logic [ND_W-1:0]  m2_nd_r [3];
  logic [RN_W-1:0]  m2_rsn_r, m2_rpn_r;
  logic [RD_W-1:0]  m2_rsd_r, m2_rpd_r;
  logic [MB_W-1:0]  m2_mb_r;

  always_comb begin
    rs_diff = (m1_ps_r > m1_qs_r) ? m1_ps_r - m1_qs_r : m1_qs_r - m1_ps_r;
    rp_diff = (m1_nci_r > m1_qp_r) ? m1_nci_r - m1_qp_r : m1_qp_r - m1_nci_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (adv) m2_v_r <= m1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_nci_r <= m1_nci_r;
      m2_den_r <= m1_den_r;
      m2_nd_r  <= m1_nd_r;
      m2_rsn_r <= RN_W'(rs_diff) << 16;
      m2_rpn_r <= RN_W'(rp_diff) << 16;
      m2_rsd_r <= RD_W'(m1_ps_r) + RD_W'(m1_qs_r);
      m2_rpd_r <= RD_W'(m1_nci_r) + RD_W'(m1_qp_r);
      m2_mb_r  <= {m1_ex_r, m1_tir_r, m1_kpos_r, m1_dneg_r, m1_sk_r, m1_nv_r};
    end
  end

  // ---- eta and Fresnel divisions ----
  logic [EQ_W-1:0] q_ci, q_rs, q_rp;
  logic [EQ_W-1:0] q_d [3];
  logic [2:0]      rz_d;
  logic            dm_v;
  logic [MB_W-1:0] dm_mb;

  srf_div #(.NUM_W(NC_W), .DEN_W(IDX_W), .Q_W(EQ_W)) u_div_ci (
    .clk(clk), .en(adv), .num(m2_nci_r), .den(m2_den_r),
    .q(q_ci), .rem_nz(), .ovf()
  );
  for (genvar i = 0; i < 3; i++) begin : g_ddiv
    srf_div #(.NUM_W(ND_W), .DEN_W(IDX_W), .Q_W(EQ_W)) u_div_d (
      .clk(clk), .en(adv), .num(m2_nd_r[i]), .den(m2_den_r),
      .q(q_d[i]), .rem_nz(rz_d[i]), .ovf()
    );
  end
  srf_div #(.NUM_W(RN_W), .DEN_W(RD_W), .Q_W(EQ_W)) u_div_rs (
    .clk(clk), .en(adv), .num(m2_rsn_r), .den(m2_rsd_r),
    .q(q_rs), .rem_nz(), .ovf()
  );
  srf_div #(.NUM_W(RN_W), .DEN_W(RD_W), .Q_W(EQ_W)) u_div_rp (
    .clk(clk), .en(adv), .num(m2_rpn_r), .den(m2_rpd_r),
    .q(q_rp), .rem_nz(), .ovf()
  );
  srf_delay #(.W(MB_W), .D(EQ_W)) u_dly_eta (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(m2_v_r), .din(m2_mb_r),
    .vld_out(dm_v), .dout(dm_mb)
  );

  // ---- stage M3: coefficient, signed eta*d, squares ----
  logic signed [CO_W-1:0] coef_nxt;
  logic signed [ED_W-1:0] ed_nxt [3];
  logic signed [ED_W-1:0] ed_mag;
  logic [CI_W-1:0]        sk3;
  logic [2:0]             dneg3;

  logic                   m3_v_r, m3_ex_r, m3_tir_r, m3_kpos_r;
  logic signed [CO_W-1:0] m3_coef_r;
  logic signed [ED_W-1:0] m3_ed_r [3];
  logic [33:0]            m3_rs2_r, m3_rp2_r;
  logic [3*NV_W-1:0]      m3_nv_r;

  always_comb begin
    sk3      = dm_mb[3*NV_W +: CI_W];
    dneg3    = dm_mb[3*NV_W + CI_W +: 3];
    coef_nxt = CO_W'($signed({1'b0, q_ci})) - CO_W'($signed({1'b0, sk3}));
    for (int i = 0; i < 3; i++) begin
      ed_mag    = $signed(ED_W'(q_d[i]) + ED_W'(rz_d[i] & dneg3[i]));
      ed_nxt[i] = dneg3[i] ? -ed_mag : ed_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m3_v_r <= 1'b0;
    else if (adv) m3_v_r <= dm_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m3_ex_r   <= dm_mb[MB_W-1];
      m3_tir_r  <= dm_mb[MB_W-2];
      m3_kpos_r <= dm_mb[MB_W-3];
      m3_coef_r <= coef_nxt;
      m3_ed_r   <= ed_nxt;
      m3_rs2_r  <= 34'(q_rs[16:0]) * 34'(q_rs[16:0]);
      m3_rp2_r  <= 34'(q_rp[16:0]) * 34'(q_rp[16:0]);
      m3_nv_r   <= dm_mb[0 +: 3*NV_W];
    end
  end

  // ---- stage M4: coef * normal, reflectance ----
  logic signed [PR_W-1:0] pr_nxt [3];
  logic [34:0]            rsum;
  logic [17:0]            rsh;
  logic [15:0]            refl_nxt;

  logic                   st4v_r, m4_ex_r, m4_tir_r, m4_kpos_r;
  logic signed [PR_W-1:0] m4_pr_r [3];
  logic signed [ED_W-1:0] m4_ed_r [3];
  logic [15:0]            m4_refl_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      pr_nxt[i] = PR_W'(m3_coef_r) * PR_W'($signed(m3_nv_r[NV_W*i +: NV_W]));
    rsum     = 35'(m3_rs2_r) + 35'(m3_rp2_r);
    rsh      = rsum[34:17];
    refl_nxt = (rsh > 18'(REFL_MAX)) ? REFL_MAX : rsh[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st4v_r <= 1'b0;
    else if (adv) st4v_r <= m3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m4_ex_r   <= m3_ex_r;
      m4_tir_r  <= m3_tir_r;
      m4_kpos_r <= m3_kpos_r;
      m4_pr_r   <= pr_nxt;
      m4_ed_r   <= m3_ed_r;
      m4_refl_r <= refl_nxt;
    end
  end

  // ---- output register ----
  logic signed [T_W-1:0]  t_sum [3];
  logic [3*VEC_W-1:0]     dir_nxt;
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r, user_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_sum[i] = T_W'(m4_ed_r[i]) + T_W'(m4_pr_r[i] >>> F);
      priority if (m4_tir_r) dir_nxt[VEC_W*i +: VEC_W] = '0;
      else if (t_sum[i] > SAT_HI) dir_nxt[VEC_W*i +: VEC_W] = 16'h7FFF;
      else if (t_sum[i] < SAT_LO) dir_nxt[VEC_W*i +: VEC_W] = 16'h8000;
      else dir_nxt[VEC_W*i +: VEC_W] = t_sum[i][VEC_W-1:0];
    end
    user_nxt = '0;
    user_nxt[TUSER_TIR]  = m4_tir_r;
    user_nxt[TUSER_EXIT] = m4_ex_r;
  end

  assign adv = !st4v_r || !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv && st4v_r) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (adv && st4v_r) begin
      out_data_r <= {(m4_kpos_r ? m4_refl_r : REFL_MAX), dir_nxt};
      out_user_r <= user_nxt;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[TUSER_TIR] |-> (out_tdata[47:0] == '0) &&
                                           (out_tdata[63:48] == REFL_MAX))
    else $error("total reflection result not zero direction with full reflectance");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> st4v_r && out_v_r && !out_tready)
    else $error("input held off without a full output");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    st4v_r && adv |=> out_v_r)
    else $error("finished item not moved to output register");
`endif
endmodule

// ===== hdl/srf_delay.sv =====
// Delay line for side data and valid bits, advancing on enable.
`timescale 1ns / 1ps
module srf_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_in,
  input  logic [W-1:0] din,
  output logic         vld_out,
  output logic [W-1:0] dout
);
  logic [W-1:0] dl_r [D];
  logic         vl_r [D];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) vl_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = D - 1; i > 0; i--) vl_r[i] <= vl_r[i-1];
      vl_r[0] <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = D - 1; i > 0; i--) dl_r[i] <= dl_r[i-1];
      dl_r[0] <= din;
    end
  end

  assign vld_out = vl_r[D-1];
  assign dout    = dl_r[D-1];
endmodule

// ===== hdl/srf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module srf_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 14,
  parameter int Q_W   = 28
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   q,
  output logic             rem_nz,
  output logic             ovf
);
  localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic             ovf_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    localparam int B = Q_W - 1 - s;
    logic [NUM_W-1:0] ri;
    logic [DEN_W-1:0] di;
    logic [Q_W-1:0]   qi;
    logic             oi;
    logic [CW-1:0]    r_ext;
    logic [CW-1:0]    sh;
    logic             ge;

    if (s == 0) begin : g_first
      assign ri = num;
      assign di = den;
      assign qi = '0;
      assign oi = (CW'(num) >= (CW'(den) << Q_W));
    end else begin : g_rest
      assign ri = rem_r[s-1];
      assign di = den_r[s-1];
      assign qi = q_r[s-1];
      assign oi = ovf_r[s-1];
    end

    always_comb begin
      r_ext = CW'(ri);
      sh    = CW'(di) << B;
      ge    = (r_ext >= sh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? NUM_W'(r_ext - sh) : ri;
        den_r[s] <= di;
        q_r[s]   <= qi | (Q_W'(ge) << B);
        ovf_r[s] <= oi;
      end
    end
  end

  assign q      = q_r[Q_W-1];
  assign rem_nz = |rem_r[Q_W-1];
  assign ovf    = ovf_r[Q_W-1];
endmodule

// ===== hdl/srf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module srf_sqrt #(
  parameter int RW = 15
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*RW-2:0]   arg,
  output logic [RW-1:0]     root
);
  localparam int IW = 2 * RW;

  logic [IW-1:0] v_r   [RW];
  logic [IW-1:0] res_r [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stg
    localparam int SH = 2 * (RW - 1 - s);
    logic [IW-1:0] vi;
    logic [IW-1:0] ri;
    logic [IW-1:0] bt;
    logic [IW-1:0] t;

    if (s == 0) begin : g_first
      assign vi = IW'(arg);
      assign ri = '0;
    end else begin : g_rest
      assign vi = v_r[s-1];
      assign ri = res_r[s-1];
    end

    always_comb begin
      bt = IW'(1) << SH;
      t  = ri + bt;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= t) begin
          v_r[s]   <= vi - t;
          res_r[s] <= (ri >> 1) + bt;
        end else begin
          v_r[s]   <= vi;
          res_r[s] <= ri >> 1;
        end
      end
    end
  end

  assign root = res_r[RW-1][RW-1:0];
endmodule
